FILE: hdl/atrd_pkg.sv
package atrd_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 15;

  // Default build settings
  localparam int DEF_ANGLE_FRAC_BITS = 6;
  localparam int DEF_CORDIC_STAGES   = 16;

  // Internal fixed-point formats
  localparam int VEC_W     = 36;  // CORDIC vector, samples scaled by 2^16
  localparam int ACC_W     = 36;  // angle accumulator, degrees scaled by 2^24
  localparam int ACC_FRAC  = 24;
  localparam int TABLE_LEN = 24;
  localparam int SQRT_BITS = 32;

  // Configuration register indexes
  localparam logic [1:0] REG_AZIMUTH_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_ALTITUDE_THRESHOLD = 2'd1;

  // atan(2^-i) in degrees scaled by 2^24
  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    36'sd754974720, 36'sd445687602, 36'sd235489088, 36'sd119537938,
    36'sd60000934,  36'sd30029717,  36'sd15018523,  36'sd7509720,
    36'sd3754917,   36'sd1877466,   36'sd938734,    36'sd469367,
    36'sd234684,    36'sd117342,    36'sd58671,     36'sd29335,
    36'sd14668,     36'sd7334,      36'sd3667,      36'sd1833,
    36'sd917,       36'sd458,       36'sd229,       36'sd115
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] azimuth_angle;
    logic [ANGLE_W-1:0] altitude_angle;
    logic               azimuth_up;
    logic               altitude_up;
  } result_t;

endpackage

FILE: hdl/accel_tilt_to_relay_drive_core.sv
// Accelerometer tilt to relay drive.
// Input: raise start with a signed three-axis sample; it is taken at any edge
// where busy is low. busy is high only while rst is asserted.
// Output: done pulses for one cycle with the result: roll atan2(y,z) and pitch
// atan2(-x, sqrt(y^2+z^2)) in degrees with ANGLE_FRAC_BITS fraction bits,
// wrapped to [0,360), plus the up/down relay choice for each angle.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 azimuth
// threshold, 1 altitude threshold); unknown indexes are ignored.
// Pipeline: the squares, then their sum, a square root with one result bit
// per stage, a quadrant fold, a register for each CORDIC micro-rotation, then
// wrap and rounding, then the threshold compare.
// Throughput: one sample per cycle; both angles run in parallel CORDIC lanes.
// Reset clears every pipeline valid bit and sets both thresholds to 180
// degrees. The receiver cannot stall; results are never held back.
module accel_tilt_to_relay_drive_core
  import atrd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sample_t             sample,
  output logic                done,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [ANGLE_W-1:0]  cfg_data
);

  localparam int N     = CORDIC_STAGES;
  localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ANGLE_W-1:0] THRESH_RESET = ANGLE_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] DEG90  = ACC_W'(90) <<< ACC_FRAC;
  localparam logic signed [ACC_W-1:0] DEG360 = ACC_W'(360) <<< ACC_FRAC;
  localparam logic [ACC_W-1:0] RND  = ACC_W'(1) << (SH - 1);
  localparam logic [ACC_W-1:0] FULL = ACC_W'(360) << ANGLE_FRAC_BITS;

  // Threshold registers
  logic [ANGLE_W-1:0] azimuth_threshold;
  logic [ANGLE_W-1:0] altitude_threshold;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      azimuth_threshold  <= THRESH_RESET;
      altitude_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_AZIMUTH_THRESHOLD)  azimuth_threshold  <= cfg_data;
      if (cfg_index == REG_ALTITUDE_THRESHOLD) altitude_threshold <= cfg_data;
    end
  end

  // Stage 1: squares of y and z
  logic        v1;
  sample_t     s1;
  logic [31:0] sq_y, sq_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    s1   <= sample;
    sq_y <= $unsigned(32'(sample.accel_y) * 32'(sample.accel_y));
    sq_z <= $unsigned(32'(sample.accel_z) * 32'(sample.accel_z));
  end

  // Stage 2: sum of squares, loaded into the root pipeline
  logic        sq_vld [SQRT_BITS+1];
  sample_t     sq_smp [SQRT_BITS+1];
  logic [63:0] sq_rem [SQRT_BITS+1];
  logic [63:0] sq_res [SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else     sq_vld[0] <= v1;
    sq_smp[0] <= s1;
    sq_rem[0] <= {(sq_y + sq_z), 32'd0};
    sq_res[0] <= 64'd0;
  end

  // Square root: one result bit per stage
  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    localparam logic [63:0] BITC = 64'd1 << (2 * (SQRT_BITS - 1 - j));
    logic [63:0] trial;
    assign trial = sq_res[j] + BITC;

    always_ff @(posedge clk) begin
      if (rst) sq_vld[j+1] <= 1'b0;
      else     sq_vld[j+1] <= sq_vld[j];
      sq_smp[j+1] <= sq_smp[j];
      if (sq_rem[j] >= trial) begin
        sq_rem[j+1] <= sq_rem[j] - trial;
        sq_res[j+1] <= (sq_res[j] >> 1) + BITC;
      end else begin
        sq_rem[j+1] <= sq_rem[j];
        sq_res[j+1] <= sq_res[j] >> 1;
      end
    end
  end

  // CORDIC lanes: lane 0 roll, lane 1 pitch
  logic                    c_vld [N+1];
  logic signed [VEC_W-1:0] cx    [2][N+1];
  logic signed [VEC_W-1:0] cy    [2][N+1];
  logic signed [ACC_W-1:0] ca    [2][N+1];
  logic                    cz    [2][N+1];

  logic signed [VEC_W-1:0] in_y [2];
  logic signed [VEC_W-1:0] in_x [2];

  always_comb begin
    in_y[0] = VEC_W'(sq_smp[SQRT_BITS].accel_y) <<< 16;
    in_x[0] = VEC_W'(sq_smp[SQRT_BITS].accel_z) <<< 16;
    in_y[1] = -(VEC_W'(sq_smp[SQRT_BITS].accel_x) <<< 16);
    in_x[1] = $signed(VEC_W'(sq_res[SQRT_BITS][31:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld[0] <= 1'b0;
    else     c_vld[0] <= sq_vld[SQRT_BITS];
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    // Fold the left half plane onto the right by a quarter turn
    always_ff @(posedge clk) begin
      cz[l][0] <= (in_x[l] == '0) && (in_y[l] == '0);
      if (in_x[l] < 0) begin
        if (in_y[l] >= 0) begin
          cx[l][0] <= in_y[l];
          cy[l][0] <= -in_x[l];
          ca[l][0] <= DEG90;
        end else begin
          cx[l][0] <= -in_y[l];
          cy[l][0] <= in_x[l];
          ca[l][0] <= -DEG90;
        end
      end else begin
        cx[l][0] <= in_x[l];
        cy[l][0] <= in_y[l];
        ca[l][0] <= '0;
      end
    end

    // Micro-rotations driving y toward zero
    for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [VEC_W-1:0] dx, dy;
      assign dx = cy[l][i] >>> i;
      assign dy = cx[l][i] >>> i;

      always_ff @(posedge clk) begin
        cz[l][i+1] <= cz[l][i];
        if (!cy[l][i][VEC_W-1]) begin
          cx[l][i+1] <= cx[l][i] + dx;
          cy[l][i+1] <= cy[l][i] - dy;
          ca[l][i+1] <= ca[l][i] + ATAN_TAB[i];
        end else begin
          cx[l][i+1] <= cx[l][i] - dx;
          cy[l][i+1] <= cy[l][i] + dy;
          ca[l][i+1] <= ca[l][i] - ATAN_TAB[i];
        end
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) c_vld[i+1] <= 1'b0;
      else     c_vld[i+1] <= c_vld[i];
    end
  end

  // Wrap negative angles and round to the output step
  logic             r_vld;
  logic [ACC_W-1:0] r_ang [2];
  logic             r_zero [2];
  logic signed [ACC_W-1:0] wrapped [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      wrapped[l] = ca[l][N];
      if (wrapped[l] < 0) wrapped[l] = wrapped[l] + DEG360;
      if (wrapped[l] < 0) wrapped[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) r_vld <= 1'b0;
    else     r_vld <= c_vld[N];
    for (int l = 0; l < 2; l++) begin
      r_ang[l]  <= ($unsigned(wrapped[l]) + RND) >> SH;
      r_zero[l] <= cz[l][N];
    end
  end

  // Fold a zero vector or a full circle to zero, compare against thresholds
  logic [ANGLE_W-1:0] fin [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (r_zero[l])           fin[l] = '0;
      else if (r_ang[l] >= FULL) fin[l] = ANGLE_W'(r_ang[l] - FULL);
      else                     fin[l] = ANGLE_W'(r_ang[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= r_vld;
    result.azimuth_angle  <= fin[0];
    result.altitude_angle <= fin[1];
    result.azimuth_up     <= fin[0] < azimuth_threshold;
    result.altitude_up    <= fin[1] < altitude_threshold;
  end

endmodule

FILE: tb/accel_tilt_to_relay_drive_core_tb.sv
`timescale 1ns / 1ps

module accel_tilt_to_relay_drive_core_tb;
  import atrd_pkg::*;

  localparam int FRAC    = DEF_ANGLE_FRAC_BITS;
  localparam int STAGES  = DEF_CORDIC_STAGES;
  localparam int LATENCY = STAGES + 37;
  localparam logic [1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [1:0] REG_UNUSED_3 = 2'd3;

  // Tilt predictor and store of expected results
  class tilt_checker;
    logic [ANGLE_W-1:0] az_limit;
    logic [ANGLE_W-1:0] alt_limit;
    result_t pending_tilts[$];
    int errors;

    function new();
      az_limit  = ANGLE_W'(180 << FRAC);
      alt_limit = ANGLE_W'(180 << FRAC);
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [ANGLE_W-1:0] val);
      if (idx == REG_AZIMUTH_THRESHOLD) az_limit = val;
      else if (idx == REG_ALTITUDE_THRESHOLD) alt_limit = val;
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // atan2(yv, xv) in degrees with FRAC fraction bits, wrapped to [0, 360)
    function logic [ANGLE_W-1:0] heading(longint yv, longint xv);
      longint acc, t, dx, dy;
      bit [63:0] u;
      acc = 0;
      if (yv == 0 && xv == 0) return '0;
      // fold the left half plane by a quarter turn
      if (xv < 0) begin
        if (yv >= 0) begin
          t = xv; xv = yv; yv = -t;
          acc = longint'(90) << ACC_FRAC;
        end else begin
          t = xv; xv = -yv; yv = t;
          acc = -(longint'(90) << ACC_FRAC);
        end
      end
      for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
        dx = yv >>> i;
        dy = xv >>> i;
        if (yv >= 0) begin
          xv += dx; yv -= dy; acc += longint'(ATAN_TAB[i]);
        end else begin
          xv -= dx; yv += dy; acc -= longint'(ATAN_TAB[i]);
        end
      end
      if (acc < 0) acc += longint'(360) << ACC_FRAC;
      if (acc < 0) acc = 0;
      u = (64'(acc) + (64'd1 << (ACC_FRAC - FRAC - 1))) >> (ACC_FRAC - FRAC);
      if (u >= 64'(360 << FRAC)) u -= 64'(360 << FRAC);
      return u[ANGLE_W-1:0];
    endfunction

    function void note_sample(sample_t s);
      longint x, y, z, radius;
      bit [63:0] sumsq;
      result_t r;
      x = longint'(s.accel_x);
      y = longint'(s.accel_y);
      z = longint'(s.accel_z);
      sumsq = 64'(y * y + z * z);
      radius = longint'(root64(sumsq << 32));
      r.azimuth_angle  = heading(y * 65536, z * 65536);
      r.altitude_angle = heading(-x * 65536, radius);
      r.azimuth_up     = r.azimuth_angle < az_limit;
      r.altitude_up    = r.altitude_angle < alt_limit;
      pending_tilts.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending_tilts.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending_tilts.pop_front();
      if (got.azimuth_angle !== exp_r.azimuth_angle) begin
        $display("%0t: azimuth_angle expected %0d actual %0d", $realtime,
                 exp_r.azimuth_angle, got.azimuth_angle);
        errors++;
      end
      if (got.altitude_angle !== exp_r.altitude_angle) begin
        $display("%0t: altitude_angle expected %0d actual %0d", $realtime,
                 exp_r.altitude_angle, got.altitude_angle);
        errors++;
      end
      if (got.azimuth_up !== exp_r.azimuth_up) begin
        $display("%0t: azimuth_up expected %0b actual %0b", $realtime,
                 exp_r.azimuth_up, got.azimuth_up);
        errors++;
      end
      if (got.altitude_up !== exp_r.altitude_up) begin
        $display("%0t: altitude_up expected %0b actual %0b", $realtime,
                 exp_r.altitude_up, got.altitude_up);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  sample_t            sample = '0;
  logic               done;
  result_t            result;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_AZIMUTH_THRESHOLD;
  logic [ANGLE_W-1:0] cfg_data = '0;

  tilt_checker sb = new();
  bit no_gaps;

  accel_tilt_to_relay_drive_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watch both sides of the block at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_sample(sample);
      if (done) sb.check_result(result);
    end
  end

  task automatic send(sample_t s);
    int gap, pick;
    start  <= 1'b1;
    sample <= s;
    do @(posedge clk); while (busy);
    pick = $urandom_range(0, 19);
    if (no_gaps || pick < 12) gap = 0;
    else if (pick < 19) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 50);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_xyz(int x, int y, int z);
    sample_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    send(s);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ANGLE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every pending transaction has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_tilts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    int mode;
    mode = $urandom_range(0, 9);
    s.accel_x = 16'($urandom_range(0, 65535));
    s.accel_y = 16'($urandom_range(0, 65535));
    s.accel_z = 16'($urandom_range(0, 65535));
    if (mode < 3) begin
      // small readings near rest
      s.accel_x = 16'($urandom_range(0, 600) - 300);
      s.accel_y = 16'($urandom_range(0, 600) - 300);
      s.accel_z = 16'($urandom_range(0, 600) - 300);
    end else if (mode == 3) begin
      // one axis zero, near the quadrant seams
      case ($urandom_range(0, 2))
        0: s.accel_x = '0;
        1: s.accel_y = '0;
        default: s.accel_z = '0;
      endcase
    end else if (mode == 4) begin
      s.accel_y = 16'($urandom_range(0, 4) - 2);
    end
    return s;
  endfunction

  initial begin : stimulus
    logic [ANGLE_W-1:0] limits[6];
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero vector, axes, extremes, full circle wrap
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 16384);
    send_xyz(0, 0, -16384);
    send_xyz(0, 16384, 0);
    send_xyz(0, -16384, 0);
    send_xyz(16384, 0, 0);
    send_xyz(-16384, 0, 0);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(-32768, 32767, -32768);
    send_xyz(32767, -32768, 32767);
    send_xyz(0, -1, 32767);
    send_xyz(0, -1, 32767);
    send_xyz(0, 1, -32768);
    send_xyz(0, -1, -32768);
    send_xyz(-1, 0, 0);
    send_xyz(1, 0, 0);
    send_xyz(0, 0, 1);
    send_xyz(0, 1, 1);
    send_xyz(0, -1, -1);
    send_xyz(-32768, 0, 0);
    send_xyz(21845, -21846, 5);
    drain();

    // Unknown indexes must leave the thresholds alone
    write_reg(REG_UNUSED_2, '0);
    write_reg(REG_UNUSED_3, '1);
    repeat (4) send(rand_sample());
    drain();

    limits = '{15'd0, 15'd23039, 15'd32767, 15'd1, 15'd11520, 15'd5760};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) begin
        write_reg(REG_AZIMUTH_THRESHOLD, limits[ph]);
        write_reg(REG_ALTITUDE_THRESHOLD, limits[5 - ph]);
      end else begin
        write_reg(REG_AZIMUTH_THRESHOLD, ANGLE_W'($urandom_range(0, 32767)));
        write_reg(REG_ALTITUDE_THRESHOLD, ANGLE_W'($urandom_range(0, 32767)));
      end
      no_gaps = (ph % 3 == 1);
      for (int n = 0; n < 100; n++) send(rand_sample());
      drain();
    end

    // Allow for anything still in flight, then report
    start <= 1'b0;
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.pending_tilts.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, sb.pending_tilts.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS accel_tilt_to_relay_drive_core");
    end else begin
      $display("FAIL accel_tilt_to_relay_drive_core");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("FAIL accel_tilt_to_relay_drive_core");
    $finish;
  end

endmodule
